>>> design/dss_pkg.sv
// Shared types and constants of the delimiter string splitter.
`timescale 1ns / 1ps

package dss_pkg;

  typedef struct packed {
    logic shift;
    logic load;
    logic en;
  } cell_ctrl_t;

  localparam logic [1:0] REG_DELIM_LEN   = 2'd0;
  localparam logic [1:0] REG_DELIM_BYTES = 2'd1;
  localparam logic [1:0] REG_KEEP_EMPTY  = 2'd2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [3:0]  DELIM_LEN_RST   = 4'd1;
  localparam logic [63:0] DELIM_BYTES_RST = 64'd44;

endpackage

>>> design/delimiter_string_splitter.sv
// Top level of the delimiter string splitter: item sequencer, cell row and register port.
//
// The input channel carries one string byte per beat: in_tdata is the byte, in_tuser says
// whether the beat carries a byte and in_tlast marks the end of the string. The result
// channel carries one result per beat: out_tdata is a token byte (zero on a marker),
// out_tuser holds the kind and the string-done flag, and out_tlast marks the last result
// caused by one input beat. The user must set the delimiter, its length and the
// keep-empty mode through the register port only while the block is idle; the block does
// not enforce it. An accepted beat is held in an input register and worked on in the next
// cycle; its results are registered at the output. The window is a row of byte cells that
// shifts by one cell per advance, so the block takes one input beat per cycle as long as
// the receiver does not stall and each beat that does not end the string causes at most
// one result. A beat with several results is held until each has passed the single result
// register. A beat that ends the string can also have steps without a result: the step
// that stores its byte and the slot of the final marker can pass empty. Reset empties the
// window, clears the token state and loads a one-byte comma delimiter. When the receiver
// stalls, the pending result holds in the output register, and the block keeps taking
// input beats as long as they cause no further result.
`timescale 1ns / 1ps

module delimiter_string_splitter import dss_pkg::*; #(
  parameter int unsigned MAX_DELIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // ends_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic [1:0]  out_tuser,  // out_kind, string_done
  output logic        out_tlast,  // run_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned WIN_DEPTH = (MAX_DELIM < 8) ? MAX_DELIM : 8;
  localparam int unsigned LW        = $clog2(WIN_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_PUSH = 3'b001,
    PH_MARK = 3'b010,
    PH_END  = 3'b100
  } phase_t;

  logic [3:0]  delim_len_r;
  logic [63:0] delim_bytes_r;
  logic        keep_r;

  logic        cur_v_r;
  logic [7:0]  cur_data_r;
  logic        cur_ends_r;
  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [LW-1:0] cnt_r;
  logic [LW-1:0] cnt_nxt;
  logic        ne_r;
  logic        ne_nxt;

  logic        out_v_r;
  logic [7:0]  out_data_r;
  logic        out_kind_r;
  logic        out_done_r;
  logic        out_last_r;

  logic [3:0]    len_sat;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] cnt_inc;
  logic [LW-1:0] wr_pos;
  logic          emit;
  logic          e_kind;
  logic [7:0]    e_data;
  logic          e_last;
  logic          done;
  logic          shift;
  logic          load;
  logic          hit;
  logic          can_load;
  logic          adv;
  logic          in_acc;
  logic          cfg_wr;

  logic [7:0]           cell_q [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] cell_eq;
  logic [WIN_DEPTH-1:0] cell_ok;

  assign len_sat = (delim_len_r > 4'(WIN_DEPTH)) ? 4'(WIN_DEPTH) : delim_len_r;
  assign len_eff = LW'(len_sat);
  assign cnt_inc = cnt_r + LW'(1);
  assign hit     = &cell_ok;

  genvar gi;
  generate
    for (gi = 0; gi < WIN_DEPTH; gi++) begin : g_cell
      cell_ctrl_t ctrl;
      logic [7:0] right_data;

      assign ctrl.shift = shift;
      assign ctrl.load  = load && (wr_pos == LW'(gi));
      assign ctrl.en    = adv;

      if (gi == WIN_DEPTH - 1) begin : g_tail
        assign right_data = 8'h00;
      end else begin : g_body
        assign right_data = cell_q[gi+1];
      end

      dss_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .right_data (right_data),
        .in_data    (cur_data_r),
        .ref_data   (delim_bytes_r[8*gi +: 8]),
        .data_q     (cell_q[gi]),
        .eq         (cell_eq[gi])
      );

      assign cell_ok[gi] = (LW'(gi) >= len_eff) || cell_eq[gi];
    end
  endgenerate

  always_comb begin
    emit      = 1'b0;
    e_kind    = KIND_DATA;
    e_data    = cell_q[0];
    e_last    = 1'b0;
    done      = 1'b0;
    shift     = 1'b0;
    load      = 1'b0;
    wr_pos    = cnt_r;
    cnt_nxt   = cnt_r;
    ne_nxt    = ne_r;
    phase_nxt = phase_r;
    if (len_eff == '0) begin
      cnt_nxt = '0;
      ne_nxt  = 1'b0;
      done    = 1'b1;
    end else begin
      case (phase_r)
        PH_PUSH: begin
          if (cnt_r > len_eff) begin
            emit    = 1'b1;
            shift   = 1'b1;
            cnt_nxt = cnt_r - LW'(1);
            ne_nxt  = 1'b1;
          end else if (cnt_r == len_eff) begin
            emit   = 1'b1;
            shift  = 1'b1;
            load   = 1'b1;
            wr_pos = len_eff - LW'(1);
            ne_nxt = 1'b1;
            if (hit) begin
              cnt_nxt   = '0;
              phase_nxt = PH_MARK;
            end else if (cur_ends_r) begin
              phase_nxt = PH_END;
            end else begin
              e_last = 1'b1;
              done   = 1'b1;
            end
          end else begin
            load    = 1'b1;
            cnt_nxt = cnt_inc;
            if ((cnt_inc == len_eff) && hit) begin
              cnt_nxt = '0;
              ne_nxt  = 1'b0;
              emit    = ne_r || keep_r;
              e_kind  = KIND_MARK;
              e_data  = 8'h00;
              e_last  = !(cur_ends_r && keep_r);
            end
            if (cur_ends_r) begin
              phase_nxt = PH_END;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_MARK: begin
          emit   = 1'b1;
          e_kind = KIND_MARK;
          e_data = 8'h00;
          e_last = !(cur_ends_r && keep_r);
          ne_nxt = 1'b0;
          if (cur_ends_r) begin
            phase_nxt = PH_END;
          end else begin
            done = 1'b1;
          end
        end
        PH_END: begin
          if (!cur_ends_r) begin
            done = 1'b1;
          end else if (cnt_r != '0) begin
            emit    = 1'b1;
            shift   = 1'b1;
            cnt_nxt = cnt_r - LW'(1);
            ne_nxt  = 1'b1;
          end else begin
            emit   = ne_r || keep_r;
            e_kind = KIND_MARK;
            e_data = 8'h00;
            e_last = 1'b1;
            ne_nxt = 1'b0;
            done   = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign can_load  = !out_v_r || out_tready;
  assign adv       = cur_v_r && (!emit || can_load);
  assign in_tready = !cur_v_r || (adv && done);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      phase_r <= PH_PUSH;
      cnt_r   <= '0;
      ne_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        cnt_r <= cnt_nxt;
        ne_r  <= ne_nxt;
      end
      if (in_acc) begin
        phase_r <= in_tuser ? PH_PUSH : PH_END;
      end else if (adv) begin
        phase_r <= phase_nxt;
      end
      if (in_acc) begin
        cur_v_r <= 1'b1;
      end else if (adv && done) begin
        cur_v_r <= 1'b0;
      end
      if (adv && emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_data_r <= in_tdata;
      cur_ends_r <= in_tlast;
    end
    if (adv && emit) begin
      out_data_r <= e_data;
      out_kind_r <= e_kind;
      out_last_r <= e_last;
      out_done_r <= e_last && cur_ends_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_done_r, out_kind_r};
  assign out_tlast  = out_last_r;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r   <= DELIM_LEN_RST;
      delim_bytes_r <= DELIM_BYTES_RST;
      keep_r        <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_DELIM_LEN:   delim_len_r   <= cfg_pwdata[3:0];
        REG_DELIM_BYTES: delim_bytes_r <= cfg_pwdata;
        REG_KEEP_EMPTY:  keep_r        <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_DELIM_LEN:   cfg_prdata = {60'd0, delim_len_r};
      REG_DELIM_BYTES: cfg_prdata = delim_bytes_r;
      REG_KEEP_EMPTY:  cfg_prdata = {63'd0, keep_r};
      default:         cfg_prdata = 64'd0;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LW'(WIN_DEPTH))
    else $error("window count beyond window depth");

  a_mark_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && (phase_r == PH_MARK)) |-> (ne_r && (cnt_r == '0)))
    else $error("pending marker without a cleared window and open token");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("string end flagged on a result that is not the last of its beat");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && done && cur_ends_r) |=> ((cnt_r == '0) && !ne_r))
    else $error("window or token state left over after string end");

endmodule

>>> design/dss_cell.sv
// One byte cell of the match window, with its compare against the delimiter.
`timescale 1ns / 1ps

module dss_cell import dss_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] right_data,
  input  logic [7:0] in_data,
  input  logic [7:0] ref_data,
  output logic [7:0] data_q,
  output logic       eq
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = in_data;
    end else if (ctrl.shift) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      data_r <= data_nxt;
    end
  end

  assign data_q = data_r;
  assign eq     = (data_nxt == ref_data);

endmodule
